// ===== rtl/core/ldf_pkg.sv =====
package ldf_pkg;

    localparam int COORD_BITS = 20;
    localparam int DIFF_W     = COORD_BITS + 1;
    localparam int MAG_W      = (DIFF_W > 31) ? 31 : DIFF_W;
    localparam int SQ_W       = 2 * MAG_W;
    localparam int DIST_W     = MAG_W + 1;
    localparam int RAD_W      = 2 * DIST_W;
    localparam int RANGE_W    = 20;
    localparam int Q_W        = 16;
    localparam int RATIO_W    = 15;
    localparam int FRAC_W     = 12;
    localparam int CFG_IDX_W  = 8;
    localparam int CFG_DATA_W = 20;

    localparam logic [CFG_IDX_W-1:0] REG_RANGE_LENGTH = 8'd0;
    localparam logic [CFG_IDX_W-1:0] REG_UNITY_SCALE  = 8'd1;
    localparam logic [CFG_IDX_W-1:0] REG_BASE_VALUE   = 8'd2;
    localparam logic [CFG_IDX_W-1:0] REG_FLOOR_VALUE  = 8'd3;

    localparam logic [RANGE_W-1:0] RANGE_RESET = 20'd16;
    localparam logic signed [Q_W-1:0] BASE_RESET  = 16'sd4096;
    localparam logic signed [Q_W-1:0] FLOOR_RESET = 16'sd0;
    localparam logic [RATIO_W-1:0] RATIO_MAX   = 15'h7FFF;

    typedef logic signed [COORD_BITS-1:0] t_coord;

endpackage

// ===== rtl/core/ldf_if.sv =====
interface ldf_in_if;
    import ldf_pkg::*;
    logic   valid;
    logic   ready;
    t_coord src_x;
    t_coord src_y;
    t_coord src_z;
    t_coord dst_x;
    t_coord dst_y;
    t_coord dst_z;
    modport source (output valid, src_x, src_y, src_z, dst_x, dst_y, dst_z, input ready);
    modport sink   (input valid, src_x, src_y, src_z, dst_x, dst_y, dst_z, output ready);
endinterface

interface ldf_out_if;
    import ldf_pkg::*;
    logic                  valid;
    logic                  ready;
    logic signed [Q_W-1:0] weight;
    modport source (output valid, weight, input ready);
    modport sink   (input valid, weight, output ready);
endinterface

interface ldf_cfg_if;
    import ldf_pkg::*;
    logic                  valid;
    logic                  ready;
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] data;
    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

// ===== rtl/core/linear_distance_falloff.sv =====
// Linear distance falloff: every request of two Q16.4 points yields one signed
// Q4.12 weight, base_value - dist/range_length, saturated and clamped at
// floor_value, or base_value alone when unity_scale is clear. One request is
// taken every cycle unless the output stalls. Requests pass the difference,
// magnitude, square and sum registers, the bit-per-stage square root, 15-bit
// quotient pipeline and output register; all hold while the output waits.
module linear_distance_falloff
    import ldf_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    ldf_in_if.sink    i_in,
    ldf_cfg_if.sink   i_cfg,
    ldf_out_if.source o_out
);

    logic [RANGE_W-1:0]    r_range;
    logic                  r_unity;
    logic signed [Q_W-1:0] r_base;
    logic signed [Q_W-1:0] r_floor;

    logic                     w_en;
    logic signed [DIFF_W-1:0] r_d   [3];
    logic [MAG_W-1:0]         r_mag [3];
    logic [SQ_W-1:0]          r_sq  [3];
    logic [RAD_W-1:0]         r_sum;
    logic                     r_v1, r_v2, r_v3, r_v4;
    logic                     r_h2, r_h3, r_h4;
    logic signed [DIFF_W-1:0] w_abs [3];
    logic                     w_huge;
    logic                     w_sq_v, w_sq_tag;
    logic [DIST_W-1:0]        w_dist;
    logic                     w_div_v;
    logic [RATIO_W-1:0]       w_ratio;
    logic signed [Q_W:0]      w_diff;
    logic signed [Q_W-1:0]    w_sat;
    logic signed [Q_W-1:0]    n_weight;
    logic                     r_out_v;
    logic signed [Q_W-1:0]    r_weight;

    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_range <= RANGE_RESET;
            r_unity <= 1'b1;
            r_base  <= BASE_RESET;
            r_floor <= FLOOR_RESET;
        end else if (i_cfg.valid) begin
            unique case (i_cfg.index)
                REG_RANGE_LENGTH: r_range <= i_cfg.data[RANGE_W-1:0];
                REG_UNITY_SCALE:  r_unity <= i_cfg.data[0];
                REG_BASE_VALUE:   r_base  <= i_cfg.data[Q_W-1:0];
                REG_FLOOR_VALUE:  r_floor <= i_cfg.data[Q_W-1:0];
                default: ;
            endcase
        end
    end

    assign w_en        = !r_out_v || o_out.ready;
    assign i_in.ready  = w_en;

    always_comb begin
        w_huge = 1'b0;
        for (int i = 0; i < 3; i++) begin
            w_abs[i] = r_d[i][DIFF_W-1] ? -r_d[i] : r_d[i];
            if ((DIFF_W'(w_abs[i]) >> 31) != '0) w_huge = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
            r_v4 <= 1'b0;
        end else if (w_en) begin
            r_v1 <= i_in.valid;
            r_v2 <= r_v1;
            r_v3 <= r_v2;
            r_v4 <= r_v3;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_d[0] <= DIFF_W'(i_in.dst_x) - DIFF_W'(i_in.src_x);
            r_d[1] <= DIFF_W'(i_in.dst_y) - DIFF_W'(i_in.src_y);
            r_d[2] <= DIFF_W'(i_in.dst_z) - DIFF_W'(i_in.src_z);
            for (int i = 0; i < 3; i++) begin
                r_mag[i] <= w_abs[i][MAG_W-1:0];
                r_sq[i]  <= SQ_W'(r_mag[i] * r_mag[i]);
            end
            r_h2  <= w_huge;
            r_h3  <= r_h2;
            r_sum <= RAD_W'(r_sq[0]) + RAD_W'(r_sq[1]) + RAD_W'(r_sq[2]);
            r_h4  <= r_h3;
        end
    end

    ldf_sqrt u_sqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_valid (r_v4),
        .i_tag   (r_h4),
        .i_rad   (r_sum),
        .o_valid (w_sq_v),
        .o_tag   (w_sq_tag),
        .o_root  (w_dist)
    );

    ldf_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_valid (w_sq_v),
        .i_huge  (w_sq_tag),
        .i_dist  (w_dist),
        .i_range (r_range),
        .o_valid (w_div_v),
        .o_ratio (w_ratio)
    );

    always_comb begin
        w_diff = (Q_W+1)'(r_base) - $signed({2'b00, w_ratio});
        if (w_diff < -(Q_W+1)'(32768)) w_sat = {1'b1, {(Q_W-1){1'b0}}};
        else                           w_sat = w_diff[Q_W-1:0];
        if (!r_unity)             n_weight = r_base;
        else if (w_sat < r_floor) n_weight = r_floor;
        else                      n_weight = w_sat;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_v <= 1'b0;
        end else if (w_en) begin
            r_out_v <= w_div_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) r_weight <= n_weight;
    end

    assign o_out.valid  = r_out_v;
    assign o_out.weight = r_weight;

    a_reset_empty: assert property (@(posedge i_clk) !i_rst_n |=> !r_out_v)
        else $error("output valid directly after reset");
    a_floor: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_div_v && r_unity) |-> (n_weight >= r_floor))
        else $error("weight below floor");
    a_bypass: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_div_v && !r_unity) |-> (n_weight == r_base))
        else $error("bypass weight differs from base");

endmodule

// ===== rtl/core/ldf_sqrt.sv =====
module ldf_sqrt
    import ldf_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_en,
    input  logic              i_valid,
    input  logic              i_tag,
    input  logic [RAD_W-1:0]  i_rad,
    output logic              o_valid,
    output logic              o_tag,
    output logic [DIST_W-1:0] o_root
);

    localparam int REM_W = DIST_W + 3;

    logic [REM_W-1:0]  r_rem  [DIST_W];
    logic [DIST_W-1:0] r_root [DIST_W];
    logic [RAD_W-1:0]  r_rad  [DIST_W];
    logic              r_v    [DIST_W];
    logic              r_tag  [DIST_W];

    logic [REM_W-1:0]  n_rem  [DIST_W];
    logic [DIST_W-1:0] n_root [DIST_W];
    logic [RAD_W-1:0]  n_rad  [DIST_W];
    logic [REM_W-1:0]  w_rin  [DIST_W];
    logic [DIST_W-1:0] w_qin  [DIST_W];
    logic [RAD_W-1:0]  w_din  [DIST_W];
    logic [REM_W-1:0]  w_sh   [DIST_W];
    logic [REM_W-1:0]  w_trial[DIST_W];

    // One result bit per stage, two radicand bits consumed from the top.
    always_comb begin
        for (int s = 0; s < DIST_W; s++) begin
            w_rin[s] = (s == 0) ? '0 : r_rem[s-1];
            w_qin[s] = (s == 0) ? '0 : r_root[s-1];
            w_din[s] = (s == 0) ? i_rad : r_rad[s-1];
            w_sh[s]    = {w_rin[s][REM_W-3:0], w_din[s][RAD_W-1 -: 2]};
            w_trial[s] = {1'b0, w_qin[s], 2'b01};
            n_rad[s]   = {w_din[s][RAD_W-3:0], 2'b00};
            if (w_sh[s] >= w_trial[s]) begin
                n_rem[s]  = w_sh[s] - w_trial[s];
                n_root[s] = {w_qin[s][DIST_W-2:0], 1'b1};
            end else begin
                n_rem[s]  = w_sh[s];
                n_root[s] = {w_qin[s][DIST_W-2:0], 1'b0};
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int s = 0; s < DIST_W; s++) r_v[s] <= 1'b0;
        end else if (i_en) begin
            for (int s = 0; s < DIST_W; s++) r_v[s] <= (s == 0) ? i_valid : r_v[s-1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int s = 0; s < DIST_W; s++) begin
                r_rem[s]  <= n_rem[s];
                r_root[s] <= n_root[s];
                r_rad[s]  <= n_rad[s];
                r_tag[s]  <= (s == 0) ? i_tag : r_tag[s-1];
            end
        end
    end

    assign o_valid = r_v[DIST_W-1];
    assign o_tag   = r_tag[DIST_W-1];
    assign o_root  = r_root[DIST_W-1];

endmodule

// ===== rtl/core/ldf_div.sv =====
module ldf_div
    import ldf_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_en,
    input  logic               i_valid,
    input  logic               i_huge,
    input  logic [DIST_W-1:0]  i_dist,
    input  logic [RANGE_W-1:0] i_range,
    output logic               o_valid,
    output logic [RATIO_W-1:0] o_ratio
);

    localparam int CMP_W = (DIST_W > RANGE_W + 3) ? DIST_W : RANGE_W + 3;
    localparam int NS    = RATIO_W + 1;

    logic [RANGE_W-1:0] r_rem [NS];
    logic [RATIO_W-1:0] r_low [NS];
    logic [RATIO_W-1:0] r_q   [NS];
    logic               r_ovf [NS];
    logic               r_v   [NS];

    logic [RANGE_W-1:0] n_rem [NS];
    logic [RATIO_W-1:0] n_low [NS];
    logic [RATIO_W-1:0] n_q   [NS];
    logic               n_ovf [NS];
    logic [RANGE_W:0]   w_sh  [NS];
    logic [CMP_W-1:0]   w_dist_x;
    logic [CMP_W-1:0]   w_lim_x;

    assign w_dist_x = CMP_W'(i_dist);
    assign w_lim_x  = CMP_W'({i_range, 3'b000});

    // Stage 0 flags a quotient above the Q4.12 maximum, which also
    // catches a zero range; the remaining stages produce one quotient bit each.
    always_comb begin
        n_rem[0] = RANGE_W'(i_dist >> 3);
        n_low[0] = {i_dist[2:0], {FRAC_W{1'b0}}};
        n_q[0]   = '0;
        n_ovf[0] = i_huge || (w_dist_x >= w_lim_x);
        w_sh[0]  = '0;
        for (int s = 1; s < NS; s++) begin
            w_sh[s]  = {r_rem[s-1], r_low[s-1][RATIO_W-1]};
            n_low[s] = {r_low[s-1][RATIO_W-2:0], 1'b0};
            n_ovf[s] = r_ovf[s-1];
            if (w_sh[s] >= {1'b0, i_range}) begin
                n_rem[s] = RANGE_W'(w_sh[s] - {1'b0, i_range});
                n_q[s]   = {r_q[s-1][RATIO_W-2:0], 1'b1};
            end else begin
                n_rem[s] = w_sh[s][RANGE_W-1:0];
                n_q[s]   = {r_q[s-1][RATIO_W-2:0], 1'b0};
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int s = 0; s < NS; s++) r_v[s] <= 1'b0;
        end else if (i_en) begin
            for (int s = 0; s < NS; s++) r_v[s] <= (s == 0) ? i_valid : r_v[s-1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int s = 0; s < NS; s++) begin
                r_rem[s] <= n_rem[s];
                r_low[s] <= n_low[s];
                r_q[s]   <= n_q[s];
                r_ovf[s] <= n_ovf[s];
            end
        end
    end

    assign o_valid = r_v[NS-1];
    assign o_ratio = r_ovf[NS-1] ? RATIO_MAX : r_q[NS-1];

endmodule

// ===== test/linear_distance_falloff_tb.sv =====
`timescale 1ns / 1ps

module linear_distance_falloff_tb;
    import ldf_pkg::*;

    localparam int PIPE_LAT  = 4 + (COORD_BITS + 2) + 16 + 1;
    localparam int IDLE_WAIT = 200000;

    typedef struct packed {
        t_coord src_x;
        t_coord src_y;
        t_coord src_z;
        t_coord dst_x;
        t_coord dst_y;
        t_coord dst_z;
    } t_pair;

    logic i_clk;
    logic i_rst_n;

    ldf_in_if  in_ch ();
    ldf_cfg_if cfg_ch ();
    ldf_out_if out_ch ();

    linear_distance_falloff dut (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_in   (in_ch.sink),
        .i_cfg  (cfg_ch.sink),
        .o_out  (out_ch.source)
    );

    // Shadow copy of the configuration registers.
    logic [RANGE_W-1:0]    sh_range;
    logic                  sh_unity;
    logic signed [Q_W-1:0] sh_base;
    logic signed [Q_W-1:0] sh_floor;

    t_pair                 pending_pairs[$];
    logic signed [Q_W-1:0] expected_weights[$];
    int                    fail_count;
    int                    checked_count;
    int                    idle_cycles;
    int                    send_gap;
    int                    sink_gap;
    bit                    stim_done;
    bit                    hold_send;

    function automatic longint unsigned int_sqrt(longint unsigned n);
        longint unsigned res;
        longint unsigned b;
        res = 0;
        b = 64'd1 << 62;
        while (b > n) b >>= 2;
        while (b != 0) begin
            if (n >= res + b) begin
                n -= res + b;
                res = (res >> 1) + b;
            end else begin
                res >>= 1;
            end
            b >>= 2;
        end
        return res;
    endfunction

    function automatic logic signed [Q_W-1:0] falloff_weight(t_pair p);
        longint          diff[3];
        longint unsigned mag;
        longint unsigned sum;
        longint unsigned quot;
        longint          ratio;
        longint          w;
        bit              huge;
        diff[0] = longint'(p.dst_x) - longint'(p.src_x);
        diff[1] = longint'(p.dst_y) - longint'(p.src_y);
        diff[2] = longint'(p.dst_z) - longint'(p.src_z);
        if (!sh_unity) return sh_base;
        sum = 0;
        huge = 0;
        for (int i = 0; i < 3; i++) begin
            mag = (diff[i] < 0) ? -diff[i] : diff[i];
            if (mag >= 64'd1 << 31) huge = 1;
            else sum += mag * mag;
        end
        if (huge || sh_range == 0) begin
            ratio = RATIO_MAX;
        end else begin
            quot = (int_sqrt(sum) << FRAC_W) / sh_range;
            ratio = (quot > RATIO_MAX) ? RATIO_MAX : longint'(quot);
        end
        w = longint'(sh_base) - ratio;
        if (w < -32768) w = -32768;
        if (w < longint'(sh_floor)) w = sh_floor;
        return w[Q_W-1:0];
    endfunction

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    function automatic t_coord rand_coord();
        int r;
        r = $urandom_range(0, 9);
        if (r == 0) return t_coord'((1 << (COORD_BITS - 1)) - 1);
        if (r == 1) return t_coord'(-(1 << (COORD_BITS - 1)));
        if (r < 5) return t_coord'($urandom_range(0, 300) - 150);
        return t_coord'($urandom());
    endfunction

    function automatic t_pair rand_pair();
        t_pair p;
        p.src_x = rand_coord();
        p.src_y = rand_coord();
        p.src_z = rand_coord();
        // Nearby targets keep the ratio in range often enough to exercise the divide.
        if ($urandom_range(0, 1)) begin
            p.dst_x = p.src_x + t_coord'($urandom_range(0, 200) - 100);
            p.dst_y = p.src_y + t_coord'($urandom_range(0, 200) - 100);
            p.dst_z = p.src_z + t_coord'($urandom_range(0, 200) - 100);
        end else begin
            p.dst_x = rand_coord();
            p.dst_y = rand_coord();
            p.dst_z = rand_coord();
        end
        return p;
    endfunction

    function automatic t_pair make_pair(t_coord sx, t_coord sy, t_coord sz,
                                        t_coord dx, t_coord dy, t_coord dz);
        t_pair p;
        p = '{sx, sy, sz, dx, dy, dz};
        return p;
    endfunction

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    // Request driver.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            in_ch.valid <= 1'b0;
            send_gap <= 0;
        end else if (in_ch.valid && !in_ch.ready) begin
            // Hold the current request.
        end else begin
            if (in_ch.valid) begin
                expected_weights.push_back(falloff_weight({in_ch.src_x, in_ch.src_y,
                    in_ch.src_z, in_ch.dst_x, in_ch.dst_y, in_ch.dst_z}));
            end
            if (send_gap > 0) begin
                in_ch.valid <= 1'b0;
                send_gap <= send_gap - 1;
            end else if (pending_pairs.size() > 0 && !hold_send) begin
                t_pair p;
                p = pending_pairs.pop_front();
                in_ch.valid <= 1'b1;
                in_ch.src_x <= p.src_x;
                in_ch.src_y <= p.src_y;
                in_ch.src_z <= p.src_z;
                in_ch.dst_x <= p.dst_x;
                in_ch.dst_y <= p.dst_y;
                in_ch.dst_z <= p.dst_z;
                send_gap <= pick_gap();
            end else begin
                in_ch.valid <= 1'b0;
            end
        end
    end

    // Result monitor and output back-pressure.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            out_ch.ready <= 1'b0;
            sink_gap <= 0;
        end else begin
            if (out_ch.valid && out_ch.ready) begin
                if (expected_weights.size() == 0) begin
                    $display("%0t: unexpected weight %0d", $time, out_ch.weight);
                    fail_count++;
                end else begin
                    logic signed [Q_W-1:0] want;
                    want = expected_weights.pop_front();
                    checked_count++;
                    if (out_ch.weight !== want) begin
                        $display("%0t: weight mismatch expected %0d actual %0d",
                                 $time, want, out_ch.weight);
                        fail_count++;
                    end
                end
            end
            if (sink_gap > 0) begin
                out_ch.ready <= 1'b0;
                sink_gap <= sink_gap - 1;
            end else begin
                out_ch.ready <= 1'b1;
                sink_gap <= pick_gap();
            end
        end
    end

    // Watchdog on cycles without any handshake on the request, result or configuration channel.
    always @(posedge i_clk) begin
        if (!i_rst_n || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)
            || (cfg_ch.valid && cfg_ch.ready) || stim_done) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= IDLE_WAIT) begin
                $display("%0t: watchdog expired", $time);
                $display("[linear_distance_falloff] ERROR");
                $finish;
            end
        end
    end

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] value);
        cfg_ch.valid <= 1'b1;
        cfg_ch.index <= idx;
        cfg_ch.data  <= value;
        @(posedge i_clk);
        while (!cfg_ch.ready) @(posedge i_clk);
        case (idx)
            REG_RANGE_LENGTH: sh_range = value[RANGE_W-1:0];
            REG_UNITY_SCALE:  sh_unity = value[0];
            REG_BASE_VALUE:   sh_base  = value[Q_W-1:0];
            REG_FLOOR_VALUE:  sh_floor = value[Q_W-1:0];
            default: ;
        endcase
        cfg_ch.valid <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic drain();
        while (pending_pairs.size() > 0 || in_ch.valid || expected_weights.size() > 0)
            @(posedge i_clk);
        repeat (PIPE_LAT + 4) @(posedge i_clk);
    endtask

    task automatic configure(logic [RANGE_W-1:0] rl, logic uni,
                             logic [Q_W-1:0] bv, logic [Q_W-1:0] fv);
        write_reg(REG_RANGE_LENGTH, rl);
        write_reg(REG_UNITY_SCALE, CFG_DATA_W'(uni));
        write_reg(REG_BASE_VALUE, CFG_DATA_W'(bv));
        write_reg(REG_FLOOR_VALUE, CFG_DATA_W'(fv));
    endtask

    initial begin
        t_coord cmax;
        t_coord cmin;
        cmax = t_coord'((1 << (COORD_BITS - 1)) - 1);
        cmin = t_coord'(-(1 << (COORD_BITS - 1)));
        fail_count = 0;
        checked_count = 0;
        idle_cycles = 0;
        stim_done = 0;
        hold_send = 0;
        i_rst_n = 1'b0;
        in_ch.valid = 1'b0;
        {in_ch.src_x, in_ch.src_y, in_ch.src_z} = '0;
        {in_ch.dst_x, in_ch.dst_y, in_ch.dst_z} = '0;
        out_ch.ready = 1'b0;
        cfg_ch.valid = 1'b0;
        cfg_ch.index = '0;
        cfg_ch.data = '0;
        sh_range = RANGE_RESET;
        sh_unity = 1'b1;
        sh_base  = BASE_RESET;
        sh_floor = FLOOR_RESET;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed part under reset settings: zero distance, unit steps, extremes.
        pending_pairs.push_back(make_pair(0, 0, 0, 0, 0, 0));
        pending_pairs.push_back(make_pair(0, 0, 0, 16, 0, 0));
        pending_pairs.push_back(make_pair(0, 0, 0, 3, 4, 0));
        pending_pairs.push_back(make_pair(0, 0, 0, 0, 0, 8));
        pending_pairs.push_back(make_pair(cmin, cmin, cmin, cmax, cmax, cmax));
        pending_pairs.push_back(make_pair(cmax, cmax, cmax, cmin, cmin, cmin));
        pending_pairs.push_back(make_pair(-1, -1, -1, -1, -1, -1));
        drain();

        // Zero range, floor above base, extreme base and floor.
        configure(0, 1, 16'sh7FFF, 16'sh8000);
        pending_pairs.push_back(make_pair(0, 0, 0, 0, 0, 0));
        pending_pairs.push_back(make_pair(5, 5, 5, 6, 5, 5));
        drain();
        configure(20'hFFFFF, 1, 16'sh8000, 16'sh7FFF);
        pending_pairs.push_back(make_pair(0, 0, 0, 0, 0, 0));
        pending_pairs.push_back(make_pair(cmin, 0, 0, cmax, 0, 0));
        drain();
        configure(20'hFFFFF, 1, 16'sh7FFF, 16'sh8000);
        pending_pairs.push_back(make_pair(cmin, cmin, cmin, cmax, cmax, cmax));
        pending_pairs.push_back(make_pair(0, 0, 0, 1, 0, 0));
        drain();
        // Flag clear: base passes through, floor ignored.
        configure(16, 0, 16'sh8000, 16'sh7FFF);
        pending_pairs.push_back(make_pair(cmin, cmin, cmin, cmax, cmax, cmax));
        pending_pairs.push_back(make_pair(0, 0, 0, 0, 0, 0));
        drain();
        write_reg(8'd77, 20'h12345);

        // Random phases with varying settings.
        for (int ph = 0; ph < 12; ph++) begin
            configure((ph % 4 == 0) ? RANGE_W'($urandom_range(1, 4)) :
                      (ph == 5) ? '0 : RANGE_W'($urandom_range(1, (1 << RANGE_W) - 1)),
                      (ph % 6 != 3), Q_W'($urandom()),
                      (ph % 3 == 0) ? 16'sh8000 : Q_W'($urandom()));
            for (int k = 0; k < 95; k++) pending_pairs.push_back(rand_pair());
            if (ph == 6) begin
                // Pause sending part way through until the pipeline has emptied.
                while (pending_pairs.size() > 45) @(posedge i_clk);
                hold_send = 1;
                while (in_ch.valid || expected_weights.size() > 0) @(posedge i_clk);
                hold_send = 0;
            end
            drain();
        end

        stim_done = 1;
        $display("Checked %0d weights over directed extremes and 12 random configurations,",
                 checked_count);
        $display("including zero range, flag clear and output back-pressure.");
        if (fail_count == 0) begin
            $display("[linear_distance_falloff] OK");
        end else begin
            $display("[linear_distance_falloff] ERROR");
        end
        $finish;
    end

endmodule
